// ===== src/ohlc_pkg.sv =====
// Shared widths, codes and types of the OHLC candle aggregator.
package ohlc_pkg;

	localparam int TIME_W     = 32;
	localparam int PRICE_W    = 32;
	localparam int CNT_W      = 32;
	localparam int CFG_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int DIV_CNT_W  = $clog2(TIME_W);
	localparam int IN_DATA_W  = TIME_W + PRICE_W;
	localparam int OUT_DATA_W = CNT_W + TIME_W + 4 * PRICE_W;

	localparam logic [TIME_W-1:0] INTERVAL_RESET = TIME_W'(300);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CUTOFF   = 1'b0,
		CFG_INTERVAL = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_CLEAR,
		OP_MERGE,
		OP_OPEN
	} cand_op_t;

	typedef struct packed {
		cand_op_t            op;
		logic [TIME_W-1:0]   bucket;
		logic [TIME_W-1:0]   start;
		logic [PRICE_W-1:0]  price;
	} cand_cmd_t;

	typedef struct packed {
		logic                is_open;
		logic [TIME_W-1:0]   bucket;
		logic [TIME_W-1:0]   start;
		logic [PRICE_W-1:0]  first;
		logic [PRICE_W-1:0]  max;
		logic [PRICE_W-1:0]  min;
		logic [PRICE_W-1:0]  last;
		logic [CNT_W-1:0]    count;
	} cand_state_t;

endpackage

// ===== src/ohlc_candle_aggregator.sv =====
// Top level of the OHLC candle aggregator: handshakes, control and the result register.
// A kept tick goes from its transaction through the divider steps, the registered done
// flag and commit to the result register; an end item goes straight to commit.
// Input is taken only in idle, so a new item waits until the last one is through; a dropped
// tick leaves the sequencer in idle. A waiting result delays only commit.
// Reset (arst_n low) clears the candle, the count, the result valid and sets interval to 300.
module ohlc_candle_aggregator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// s_tdata fields from bit 0: timestamp[31:0], price[63:32].
	input  logic [ohlc_pkg::IN_DATA_W-1:0]       s_tdata,
	// s_tuser fields from bit 0: well_formed.
	input  logic                                 s_tuser,
	// s_tlast carries kind: high for the end-of-series item.
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// m_tdata fields from bit 0: candle_number, bucket_start, open_price, high_price,
	// low_price, close_price, 32 bits each.
	output logic [ohlc_pkg::OUT_DATA_W-1:0]      m_tdata,
	// m_tuser fields from bit 0: candle_valid.
	output logic                                 m_tuser,
	// m_tlast carries final_res: high when the end item caused the result.
	output logic                                 m_tlast,
	input  logic                                 cfg_we,
	input  logic [ohlc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ohlc_pkg::CFG_W-1:0]           cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_COMMIT
	} state_t;

	state_t                        state_q;
	logic [ohlc_pkg::TIME_W-1:0]   cutoff_q;
	logic [ohlc_pkg::TIME_W-1:0]   interval_q;
	logic [ohlc_pkg::TIME_W-1:0]   ts_q;
	logic [ohlc_pkg::PRICE_W-1:0]  price_q;
	logic                          kind_q;
	logic                          m_tvalid_q;
	logic [ohlc_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                          m_tuser_q;
	logic                          m_tlast_q;

	logic [ohlc_pkg::TIME_W-1:0]   in_ts;
	logic [ohlc_pkg::PRICE_W-1:0]  in_price;
	logic                          in_accept;
	logic                          tick_kept;
	logic [ohlc_pkg::TIME_W-1:0]   divisor;
	logic                          div_start;
	logic                          div_done;
	logic [ohlc_pkg::TIME_W-1:0]   div_quot;
	logic [ohlc_pkg::TIME_W-1:0]   div_rem;
	logic                          same_bucket;
	logic                          need_out;
	logic                          slot_free;
	logic                          commit;
	logic                          load_out;
	ohlc_pkg::cand_cmd_t           cmd;
	ohlc_pkg::cand_state_t         cand;

	assign in_ts    = s_tdata[ohlc_pkg::TIME_W-1:0];
	assign in_price = s_tdata[ohlc_pkg::IN_DATA_W-1:ohlc_pkg::TIME_W];

	// Input is taken only between items; the result register decouples the output side.
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	// A tick goes to the divider only if it is well formed and not older than the cutoff.
	assign tick_kept = !s_tlast && s_tuser && (in_ts >= cutoff_q);
	assign div_start = in_accept && tick_kept;

	// A zero interval behaves as an interval of one second.
	assign divisor = (interval_q == '0) ? ohlc_pkg::TIME_W'(1) : interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q   <= '0;
			interval_q <= ohlc_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ohlc_pkg::CFG_CUTOFF:   cutoff_q   <= cfg_data[ohlc_pkg::TIME_W-1:0];
				ohlc_pkg::CFG_INTERVAL: interval_q <= cfg_data[ohlc_pkg::TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ohlc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_ts),
		.divisor  (divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// The quotient is the bucket; bucket times interval equals timestamp minus remainder,
	// so the candle start time needs no multiplier.
	assign same_bucket = cand.is_open && (div_quot == cand.bucket);
	assign need_out    = kind_q || (cand.is_open && !same_bucket);
	assign slot_free   = !m_tvalid_q || m_tready;
	assign commit      = (state_q == ST_COMMIT) && (!need_out || slot_free);
	assign load_out    = commit && need_out;

	always_comb begin
		cmd.op     = ohlc_pkg::OP_NONE;
		cmd.bucket = div_quot;
		cmd.start  = ts_q - div_rem;
		cmd.price  = price_q;
		if (commit) begin
			if (kind_q) begin
				cmd.op = ohlc_pkg::OP_CLEAR;
			end else if (same_bucket) begin
				cmd.op = ohlc_pkg::OP_MERGE;
			end else begin
				cmd.op = ohlc_pkg::OP_OPEN;
			end
		end
	end

	ohlc_candle u_candle (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cand   (cand)
	);

	// Sequencer, captured item and result register. The candle fields go out before the
	// candle module sees the command, so the emitted values are the old candle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ts_q       <= '0;
			price_q    <= '0;
			kind_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			// A new result replaces one that leaves in the same cycle.
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						ts_q    <= in_ts;
						price_q <= in_price;
						kind_q  <= s_tlast;
						if (s_tlast) begin
							state_q <= ST_COMMIT;
						end else if (tick_kept) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (commit) begin
						state_q <= ST_IDLE;
						if (need_out) begin
							m_tuser_q  <= cand.is_open;
							m_tlast_q  <= kind_q;
							if (cand.is_open) begin
								m_tdata_q <= {cand.last, cand.min, cand.max, cand.first,
								              cand.start, cand.count};
							end else begin
								m_tdata_q <= '0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// The divider only finishes while the sequencer waits for it.
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");

	// A kept tick always starts a divide on the next cycle.
	a_kept_divides: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> (state_q == ST_DIV))
		else $error("kept tick did not enter the divide state");

	// The finished remainder lies below the divisor.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (div_rem < divisor))
		else $error("divider remainder not below divisor");

	// A result is never loaded over one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && need_out) |-> slot_free)
		else $error("result register overwritten while stalled");

endmodule

// ===== src/ohlc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ohlc_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ohlc_pkg::TIME_W-1:0]  dividend,
	input  logic [ohlc_pkg::TIME_W-1:0]  divisor,
	output logic                         done,
	output logic [ohlc_pkg::TIME_W-1:0]  quot,
	output logic [ohlc_pkg::TIME_W-1:0]  rem
);

	logic [ohlc_pkg::TIME_W-1:0]    quot_q;
	logic [ohlc_pkg::TIME_W-1:0]    rem_q;
	logic [ohlc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ohlc_pkg::TIME_W:0]      trial;
	logic [ohlc_pkg::TIME_W:0]      diff;

	// The partial remainder stays below the divisor, so the shifted trial fits one extra bit.
	assign trial = {rem_q, quot_q[ohlc_pkg::TIME_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ohlc_pkg::DIV_CNT_W'(ohlc_pkg::TIME_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!diff[ohlc_pkg::TIME_W]) begin
				rem_q  <= diff[ohlc_pkg::TIME_W-1:0];
				quot_q <= {quot_q[ohlc_pkg::TIME_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial[ohlc_pkg::TIME_W-1:0];
				quot_q <= {quot_q[ohlc_pkg::TIME_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== src/ohlc_candle.sv =====
// Open candle registers and their update on a committed tick or end item.
module ohlc_candle (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ohlc_pkg::cand_cmd_t    cmd,
	output ohlc_pkg::cand_state_t  cand
);

	ohlc_pkg::cand_state_t cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else begin
			case (cmd.op)
				ohlc_pkg::OP_CLEAR: begin
					cand_q <= '0;
				end
				ohlc_pkg::OP_MERGE: begin
					if (cmd.price > cand_q.max) begin
						cand_q.max <= cmd.price;
					end
					if (cmd.price < cand_q.min) begin
						cand_q.min <= cmd.price;
					end
					cand_q.last <= cmd.price;
				end
				ohlc_pkg::OP_OPEN: begin
					// Opening over a live candle means that candle was just emitted.
					if (cand_q.is_open) begin
						cand_q.count <= cand_q.count + 1'b1;
					end
					cand_q.is_open <= 1'b1;
					cand_q.bucket  <= cmd.bucket;
					cand_q.start   <= cmd.start;
					cand_q.first   <= cmd.price;
					cand_q.max     <= cmd.price;
					cand_q.min     <= cmd.price;
					cand_q.last    <= cmd.price;
				end
				default: begin
				end
			endcase
		end
	end

	assign cand = cand_q;

endmodule
